>>> rtl/pcc_pkg.sv
// shared types, constants and the crc-32 byte update for the png chunk crc checker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned OUT_FIELDS_W = 6 * WORD_W + 2;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned PAD_W        = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [31:0] TYPE_IHDR      = 32'h4948_4452;
    localparam logic [31:0] TYPE_PLTE      = 32'h504C_5445;
    localparam logic [31:0] TYPE_IDAT      = 32'h4944_4154;
    localparam logic [31:0] SIG_BYTES      = 32'd8;
    localparam logic [31:0] FIELD_BYTES    = 32'd4;
    localparam logic [31:0] CHUNK_OVERHEAD = 32'd12;
    localparam logic [31:0] FIRST_OFFSET   = 32'd8;

    // one input byte with its start-of-file flag
    typedef struct packed {
        logic                file_start;
        logic [BYTE_W-1:0]   data_byte;
    } pcc_item_t;

    // one chunk report
    typedef struct packed {
        logic                core_chunk;
        logic                crc_match;
        logic [WORD_W-1:0]   stored_crc;
        logic [WORD_W-1:0]   computed_crc;
        logic [WORD_W-1:0]   chunk_type;
        logic [WORD_W-1:0]   chunk_length;
        logic [WORD_W-1:0]   chunk_offset;
        logic [WORD_W-1:0]   chunk_number;
    } pcc_result_t;

    // reflected crc-32 update over one byte, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pcc_in_stage.sv
// input register of the png chunk crc checker: holds one accepted byte
// depends on pcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcc_in_stage (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [pcc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tuser,
    input  wire logic                           advance,
    output logic                                item_valid,
    output pcc_pkg::pcc_item_t                  item
);

    logic               valid_reg;
    logic               valid_next;
    pcc_pkg::pcc_item_t item_reg;
    logic               accept;

    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.file_start <= s_axis_tuser;
            item_reg.data_byte  <= s_axis_tdata[pcc_pkg::BYTE_W-1:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> rtl/pcc_parser.sv
// chunk parser and crc-32 engine: one byte per step, flags a finished chunk
// depends on pcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcc_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire pcc_pkg::pcc_item_t item,
    output logic              emit,
    output pcc_pkg::pcc_result_t result
);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC
    } phase_t;

    phase_t      phase_reg, phase_next, phase_c;
    logic [31:0] count_reg, count_next, count_c;
    logic [31:0] length_reg, length_next, length_c;
    logic [31:0] type_reg, type_next, type_c;
    logic [31:0] crc_reg, crc_next, crc_c;
    logic [31:0] trailer_reg, trailer_next, trailer_c;
    logic [31:0] offset_reg, offset_next, offset_c;
    logic [31:0] number_reg, number_next, number_c;

    logic [31:0] count_inc;
    logic [31:0] crc_upd;
    logic [31:0] trailer_sh;
    logic [31:0] computed;
    logic [7:0]  b;

    assign b = item.data_byte;

    // start of file acts as a reset in front of this byte
    always_comb
    begin
        if (item.file_start)
        begin
            phase_c   = PH_SIG;
            count_c   = '0;
            length_c  = '0;
            type_c    = '0;
            crc_c     = pcc_pkg::ALL_ONES;
            trailer_c = '0;
            offset_c  = pcc_pkg::FIRST_OFFSET;
            number_c  = '0;
        end
        else
        begin
            phase_c   = phase_reg;
            count_c   = count_reg;
            length_c  = length_reg;
            type_c    = type_reg;
            crc_c     = crc_reg;
            trailer_c = trailer_reg;
            offset_c  = offset_reg;
            number_c  = number_reg;
        end
    end

    assign count_inc  = count_c + 32'd1;
    assign crc_upd    = pcc_pkg::crc_byte(crc_c, b);
    assign trailer_sh = {trailer_c[23:0], b};
    assign computed   = crc_c ^ pcc_pkg::ALL_ONES;

    always_comb
    begin
        phase_next   = phase_c;
        count_next   = count_inc;
        length_next  = length_c;
        type_next    = type_c;
        crc_next     = crc_c;
        trailer_next = trailer_c;
        offset_next  = offset_c;
        number_next  = number_c;
        emit         = 1'b0;
        case (phase_c)
            PH_LEN:
            begin
                length_next = {length_c[23:0], b};
                if (count_inc == pcc_pkg::FIELD_BYTES)
                begin
                    phase_next = PH_TYPE;
                    count_next = '0;
                    type_next  = '0;
                    crc_next   = pcc_pkg::ALL_ONES;
                end
            end
            PH_TYPE:
            begin
                type_next = {type_c[23:0], b};
                crc_next  = crc_upd;
                if (count_inc == pcc_pkg::FIELD_BYTES)
                begin
                    count_next   = '0;
                    trailer_next = '0;
                    phase_next   = (length_c == '0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA:
            begin
                crc_next = crc_upd;
                if (count_inc == length_c)
                begin
                    count_next = '0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                trailer_next = trailer_sh;
                if (count_inc == pcc_pkg::FIELD_BYTES)
                begin
                    emit        = 1'b1;
                    number_next = number_c + 32'd1;
                    offset_next = offset_c + length_c + pcc_pkg::CHUNK_OVERHEAD;
                    phase_next  = PH_LEN;
                    count_next  = '0;
                    length_next = '0;
                end
            end
            default:
            begin
                // signature bytes are skipped unchecked
                if (count_inc >= pcc_pkg::SIG_BYTES)
                begin
                    phase_next  = PH_LEN;
                    count_next  = '0;
                    length_next = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        result.chunk_number = number_c + 32'd1;
        result.chunk_offset = offset_c;
        result.chunk_length = length_c;
        result.chunk_type   = type_c;
        result.computed_crc = computed;
        result.stored_crc   = trailer_sh;
        result.crc_match    = (computed == trailer_sh);
        result.core_chunk   = (type_c == pcc_pkg::TYPE_IHDR) ||
                              (type_c == pcc_pkg::TYPE_PLTE) ||
                              (type_c == pcc_pkg::TYPE_IDAT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIG;
            count_reg   <= '0;
            length_reg  <= '0;
            type_reg    <= '0;
            crc_reg     <= pcc_pkg::ALL_ONES;
            trailer_reg <= '0;
            offset_reg  <= pcc_pkg::FIRST_OFFSET;
            number_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            type_reg    <= type_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
            offset_reg  <= offset_next;
            number_reg  <= number_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcc_out_reg.sv
// result register of the png chunk crc checker, drives the master stream
// depends on pcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcc_out_reg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            load,
    input  wire pcc_pkg::pcc_result_t            result,
    output logic                                 busy,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [pcc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic                 valid_reg;
    logic                 valid_next;
    pcc_pkg::pcc_result_t result_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign busy          = valid_reg && !m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{pcc_pkg::PAD_W{1'b0}}, result_reg};

endmodule

`default_nettype wire

>>> rtl/png_chunk_crc_checker_top.sv
// path: an accepted byte passes the input and then the result register to its report
// throughput: 1 byte per cycle unless a chunk-ending byte waits on a stalled result
// register; the crc-32 byte update and the parse step share one cycle between the two
// reset: rst_n async active low clears both valid flags and the parser (signature phase,
// crc all ones, offset 8); a byte with tuser set restarts parsing the same way
`timescale 1ns / 1ps
`default_nettype none

module png_chunk_crc_checker_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // slave side: one file byte per transaction
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [pcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic                            s_axis_tuser,  // [0] file_start
    // master side: one chunk report per transaction
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [31:0] chunk_number, [63:32] chunk_offset, [95:64] chunk_length,
    // [127:96] chunk_type, [159:128] computed_crc, [191:160] stored_crc,
    // [192] crc_match, [193] core_chunk, [199:194] zero
    output logic [pcc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic                 item_valid;
    pcc_pkg::pcc_item_t   item;
    logic                 emit;
    pcc_pkg::pcc_result_t result;
    logic                 out_busy;
    logic                 advance;

    // a held byte moves on unless it finishes a chunk while the result register is stuck
    assign advance = item_valid && !(emit && out_busy);

    pcc_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    // parse state and running crc advance only when the byte leaves the input register
    pcc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .emit   (emit),
        .result (result)
    );

    // result register decouples the master side from the byte stream
    pcc_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && emit),
        .result        (result),
        .busy          (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/pcc_checker.sv
// port-level checks for the png chunk crc checker, bound to the top level
// depends on pcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcc_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [pcc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tuser,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [pcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled report holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("report changed while stalled");

    // match flag agrees with the two crc fields
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[192] == (m_axis_tdata[159:128] == m_axis_tdata[191:160]))
        else $error("crc_match inconsistent");

    // core flag agrees with the chunk type
    a_core: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[193] == ((m_axis_tdata[127:96] == pcc_pkg::TYPE_IHDR) ||
                                                (m_axis_tdata[127:96] == pcc_pkg::TYPE_PLTE) ||
                                                (m_axis_tdata[127:96] == pcc_pkg::TYPE_IDAT)))
        else $error("core_chunk inconsistent");

    // with no report pending the byte side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind png_chunk_crc_checker_top pcc_checker u_pcc_checker (.*);

`default_nettype wire
